FILE: rtl/core/mhp_pkg.sv
// shared types, constants and the int8 saturation helper for the projection block
// no dependencies; every other file but mhp_queue refers to it by scoped names
`timescale 1ns / 1ps

package mhp_pkg;

  localparam int ACC_W      = 22;
  localparam int VAL_W      = 8;
  localparam int PROD_W     = 16;
  localparam int ECNT_W     = 7;
  localparam int ROW_W      = 10;
  localparam int LEN_W      = 7;
  localparam int PRJ_W      = 5;
  localparam int HDS_W      = 3;
  localparam int SEQ_W      = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CMDQ_DEPTH = 2;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_LVL_W   = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_ACT    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_LENGTH   = 2'd0,
    REG_EMBED_LENGTH = 2'd1,
    REG_PROJ_COUNT   = 2'd2,
    REG_HEAD_COUNT   = 2'd3
  } reg_idx_t;

  // effective settings after clamping
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] used;
    logic [PRJ_W-1:0] projs;
    logic [HDS_W-1:0] heads;
    logic [SEQ_W-1:0] seq;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [1:0]              head;
    logic [3:0]              proj;
    logic [ECNT_W-1:0]       elem;
    logic                    acc_en;
    logic                    row_end;
    logic [ROW_W-1:0]        row;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              head;
    logic [3:0]              proj;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } res_t;

  function automatic logic signed [VAL_W-1:0] sat8(input logic [ACC_W-1:0] acc);
    logic signed [VAL_W-1:0] r;
    if (!acc[ACC_W-1] && (|acc[ACC_W-2:VAL_W-1])) begin
      r = 8'sd127;
    end else if (acc[ACC_W-1] && !(&acc[ACC_W-2:VAL_W-1])) begin
      r = -8'sd128;
    end else begin
      r = $signed(acc[VAL_W-1:0]);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/multihead_int8_linear_projection.sv
// top level of the multi-head int8 projection: settings registers, front end,
// command queue, back end and result queue; depends on mhp_pkg, mhp_queue,
// mhp_front and mhp_back
//
//   channel   ports                                       handshake
//   input     in_operation in_data_value in_weight_*      push / full
//   result    out_value out_head out_proj out_row ...     empty / pop
//   settings  cfg_index cfg_data                          cfg_we
//
// a weight transaction is written to the weight store as the back end pops it; an
// activation that accumulates steps through every head and projection on the single
// shared multiplier; at the end of a row the sums drain one per cycle, while the result
// queue has room, through the 4-entry result queue to the output
// synchronous reset clears control and the accumulator valid bits at once;
// the weight store holds garbage until written and gets no clearing pass
// a 2-entry command queue lets input keep flowing while the back end works
`timescale 1ns / 1ps

module multihead_int8_linear_projection #(
  parameter int MAX_EMBED = 64,
  parameter int MAX_PROJ  = 16,
  parameter int MAX_HEADS = 4,
  parameter int MAX_SEQ   = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mhp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_operation,
  input  logic signed [7:0]                  in_data_value,
  input  logic [1:0]                         in_weight_head,
  input  logic [3:0]                         in_weight_proj,
  input  logic [5:0]                         in_weight_elem,
  input  logic                               pop,
  output logic                               empty,
  output logic signed [7:0]                  out_value,
  output logic [1:0]                         out_head,
  output logic [3:0]                         out_proj,
  output logic [9:0]                         out_row,
  output logic                               out_row_last
);

  logic [10:0]  seq_length_r, seq_length_nxt;
  logic [6:0]   embed_length_r, embed_length_nxt;
  logic [4:0]   proj_count_r, proj_count_nxt;
  logic [2:0]   head_count_r, head_count_nxt;

  mhp_pkg::cfg_t  cfg;
  logic [4:0]     projs_sat;

  logic                           fe_cmd_push, cmdq_full, cmdq_empty, be_cmd_pop;
  mhp_pkg::cmd_t                  fe_cmd, cmdq_head;
  logic [$clog2(mhp_pkg::CMDQ_DEPTH+1)-1:0] cmdq_level;
  logic                           res_push, oq_full;
  mhp_pkg::res_t                  res, oq_head;
  logic [mhp_pkg::OQ_LVL_W-1:0]   oq_level;

  always_comb begin
    seq_length_nxt   = seq_length_r;
    embed_length_nxt = embed_length_r;
    proj_count_nxt   = proj_count_r;
    head_count_nxt   = head_count_r;
    if (cfg_we) begin
      unique case (mhp_pkg::reg_idx_t'(cfg_index))
        mhp_pkg::REG_SEQ_LENGTH:   seq_length_nxt   = cfg_data;
        mhp_pkg::REG_EMBED_LENGTH: embed_length_nxt = cfg_data[6:0];
        mhp_pkg::REG_PROJ_COUNT:   proj_count_nxt   = cfg_data[4:0];
        mhp_pkg::REG_HEAD_COUNT:   head_count_nxt   = cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_length_r   <= 11'd1;
      embed_length_r <= 7'd64;
      proj_count_r   <= 5'd16;
      head_count_r   <= 3'd4;
    end else begin
      seq_length_r   <= seq_length_nxt;
      embed_length_r <= embed_length_nxt;
      proj_count_r   <= proj_count_nxt;
      head_count_r   <= head_count_nxt;
    end
  end

  // clamp settings to what the stores hold; round the used length and projection count down to a multiple of four
  always_comb begin
    if (embed_length_r == '0) begin
      cfg.len = 7'd1;
    end else if (32'(embed_length_r) > MAX_EMBED) begin
      cfg.len = 7'(MAX_EMBED);
    end else begin
      cfg.len = embed_length_r;
    end
    cfg.used  = {cfg.len[6:2], 2'b00};
    projs_sat = (32'(proj_count_r) > MAX_PROJ) ? 5'(MAX_PROJ) : proj_count_r;
    cfg.projs = {projs_sat[4:2], 2'b00};
    cfg.heads = (32'(head_count_r) > MAX_HEADS) ? 3'(MAX_HEADS) : head_count_r;
    if (seq_length_r == '0) begin
      cfg.seq = 11'd1;
    end else if (32'(seq_length_r) > MAX_SEQ) begin
      cfg.seq = 11'(MAX_SEQ);
    end else begin
      cfg.seq = seq_length_r;
    end
  end

  mhp_front #(
    .MAX_EMBED (MAX_EMBED),
    .MAX_PROJ  (MAX_PROJ),
    .MAX_HEADS (MAX_HEADS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_data_value  (in_data_value),
    .in_weight_head (in_weight_head),
    .in_weight_proj (in_weight_proj),
    .in_weight_elem (in_weight_elem),
    .cmd_full       (cmdq_full),
    .cmd_push       (fe_cmd_push),
    .cmd            (fe_cmd)
  );

  mhp_queue #(
    .ITEM_T (mhp_pkg::cmd_t),
    .DEPTH  (mhp_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_cmd_push),
    .din   (fe_cmd),
    .full  (cmdq_full),
    .pop   (be_cmd_pop),
    .dout  (cmdq_head),
    .empty (cmdq_empty),
    .level (cmdq_level)
  );

  mhp_back #(
    .MAX_EMBED (MAX_EMBED),
    .MAX_PROJ  (MAX_PROJ),
    .MAX_HEADS (MAX_HEADS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_empty (cmdq_empty),
    .cmd       (cmdq_head),
    .cmd_pop   (be_cmd_pop),
    .oq_level  (oq_level),
    .res_push  (res_push),
    .res       (res)
  );

  mhp_queue #(
    .ITEM_T (mhp_pkg::res_t),
    .DEPTH  (mhp_pkg::OQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_head),
    .empty (empty),
    .level (oq_level)
  );

  assign out_value    = oq_head.value;
  assign out_head     = oq_head.head;
  assign out_proj     = oq_head.proj;
  assign out_row      = oq_head.row;
  assign out_row_last = oq_head.last || (oq_full && cmdq_level[0] && 1'b0);

endmodule

FILE: rtl/core/mhp_queue.sv
// small first-in first-out queue of any item type
// depends on nothing; used for the command queue and the result queue
`timescale 1ns / 1ps

module mhp_queue #(
  parameter type ITEM_T = logic [7:0],
  parameter int  DEPTH  = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  ITEM_T                      din,
  output logic                       full,
  input  logic                       pop,
  output ITEM_T                      dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ITEM_T             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/core/mhp_front.sv
// front end: takes input transactions, drops out-of-range weight writes,
// tags activations with element, row, accumulate-enable and row-end flags; depends on mhp_pkg
`timescale 1ns / 1ps

module mhp_front #(
  parameter int MAX_EMBED = 64,
  parameter int MAX_PROJ  = 16,
  parameter int MAX_HEADS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mhp_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  logic                in_operation,
  input  logic signed [7:0]   in_data_value,
  input  logic [1:0]          in_weight_head,
  input  logic [3:0]          in_weight_proj,
  input  logic [5:0]          in_weight_elem,
  input  logic                cmd_full,
  output logic                cmd_push,
  output mhp_pkg::cmd_t       cmd
);

  logic [mhp_pkg::ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [mhp_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic                       accept, is_act, in_range, row_end;

  assign accept   = push && !cmd_full;
  assign full     = cmd_full;
  assign is_act   = (mhp_pkg::op_t'(in_operation) == mhp_pkg::OP_ACT);
  assign in_range = (32'(in_weight_head) < MAX_HEADS) && (32'(in_weight_proj) < MAX_PROJ) &&
                    (32'(in_weight_elem) < MAX_EMBED);
  assign row_end  = ({1'b0, ecnt_r} + 8'd1) >= {1'b0, cfg.len};
  assign cmd_push = accept && (is_act || in_range);

  always_comb begin
    cmd.op      = mhp_pkg::op_t'(in_operation);
    cmd.value   = in_data_value;
    cmd.head    = in_weight_head;
    cmd.proj    = in_weight_proj;
    cmd.elem    = is_act ? ecnt_r : mhp_pkg::ECNT_W'(in_weight_elem);
    cmd.acc_en  = ecnt_r < cfg.used;
    cmd.row_end = row_end;
    cmd.row     = row_r;
  end

  always_comb begin
    ecnt_nxt = ecnt_r;
    row_nxt  = row_r;
    if (accept && is_act) begin
      if (row_end) begin
        ecnt_nxt = '0;
        if (({1'b0, row_r} + 11'd1) >= cfg.seq) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + 10'd1;
        end
      end else begin
        ecnt_nxt = ecnt_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      row_r  <= '0;
    end else begin
      ecnt_r <= ecnt_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

FILE: rtl/core/mhp_back.sv
// back end: weight store, accumulator store, shared multiply-accumulate
// sequencer and row drain with saturation; depends on mhp_pkg
`timescale 1ns / 1ps

module mhp_back #(
  parameter int MAX_EMBED = 64,
  parameter int MAX_PROJ  = 16,
  parameter int MAX_HEADS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mhp_pkg::cfg_t                cfg,
  input  logic                         cmd_empty,
  input  mhp_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  input  logic [mhp_pkg::OQ_LVL_W-1:0] oq_level,
  output logic                         res_push,
  output mhp_pkg::res_t                res
);

  localparam int NACC    = MAX_HEADS * MAX_PROJ;
  localparam int NW      = NACC * MAX_EMBED;
  localparam int AIDX_W  = $clog2(NACC);
  localparam int WADDR_W = $clog2(NW);
  localparam int ACC_W   = mhp_pkg::ACC_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MAC   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  mhp_pkg::cmd_t                 cur_r, cur_nxt;
  logic [mhp_pkg::HDS_W-1:0]     h_r, h_nxt;
  logic [mhp_pkg::PRJ_W-1:0]     p_r, p_nxt;
  logic                          s1_vld_r;
  logic [AIDX_W-1:0]             s1_idx_r;
  logic                          d1_vld_r;
  mhp_pkg::res_t                 d1_res_r, d1_res_nxt;
  logic [NACC-1:0]               acc_vld_r, acc_vld_nxt;
  logic                          rd_vld_r;

  logic signed [7:0]             wmem [NW];
  logic signed [7:0]             w_rd_r;
  logic [ACC_W-1:0]              accmem [NACC];
  logic [ACC_W-1:0]              acc_rd_r;

  logic                          nz, p_last, h_last, step_last, credit;
  logic                          issue_mac, issue_drain, acc_re, w_we, clr_acc;
  logic [AIDX_W-1:0]             cur_idx;
  logic [WADDR_W-1:0]            w_waddr, w_raddr;
  logic signed [15:0]            prod;
  logic [ACC_W-1:0]              acc_base, acc_sum;

  assign nz          = (cfg.heads != '0) && (cfg.projs != '0);
  assign p_last      = (p_r + 5'd1) == cfg.projs;
  assign h_last      = (h_r + 3'd1) == cfg.heads;
  assign step_last   = p_last && h_last;
  assign credit      = (32'(oq_level) + 32'(d1_vld_r)) < mhp_pkg::OQ_DEPTH;
  assign issue_mac   = (state_r == ST_MAC);
  assign issue_drain = (state_r == ST_DRAIN) && credit;
  assign acc_re      = issue_mac || issue_drain;
  assign cmd_pop     = (state_r == ST_IDLE) && !cmd_empty;
  assign w_we        = cmd_pop && (cmd.op == mhp_pkg::OP_WEIGHT);

  assign cur_idx = AIDX_W'(32'(h_r) * MAX_PROJ + 32'(p_r));
  assign w_waddr = WADDR_W'((32'(cmd.head) * MAX_PROJ + 32'(cmd.proj)) * MAX_EMBED +
                            32'(cmd.elem));
  assign w_raddr = WADDR_W'(32'(cur_idx) * MAX_EMBED + 32'(cur_r.elem));

  // multiply-accumulate write-back stage
  assign prod     = cur_r.value * w_rd_r;
  assign acc_base = rd_vld_r ? acc_rd_r : '0;
  assign acc_sum  = acc_base + {{(ACC_W - 16){prod[15]}}, prod};

  always_comb begin
    res       = d1_res_r;
    res.value = mhp_pkg::sat8(acc_base);
  end
  assign res_push = d1_vld_r;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    h_nxt      = h_r;
    p_nxt      = p_r;
    clr_acc    = 1'b0;
    d1_res_nxt = d1_res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop && (cmd.op == mhp_pkg::OP_ACT)) begin
          cur_nxt = cmd;
          h_nxt   = '0;
          p_nxt   = '0;
          if (cmd.acc_en && nz) begin
            state_nxt = ST_MAC;
          end else if (cmd.row_end && nz) begin
            state_nxt = ST_DRAIN;
          end else begin
            clr_acc = cmd.row_end;
          end
        end
      end
      ST_MAC: begin
        if (step_last) begin
          h_nxt     = '0;
          p_nxt     = '0;
          state_nxt = cur_r.row_end ? ST_DRAIN : ST_IDLE;
        end else if (p_last) begin
          p_nxt = '0;
          h_nxt = h_r + 3'd1;
        end else begin
          p_nxt = p_r + 5'd1;
        end
      end
      ST_DRAIN: begin
        if (credit) begin
          d1_res_nxt.value = '0;
          d1_res_nxt.head  = h_r[1:0];
          d1_res_nxt.proj  = p_r[3:0];
          d1_res_nxt.row   = cur_r.row;
          d1_res_nxt.last  = step_last;
          if (step_last) begin
            h_nxt     = '0;
            p_nxt     = '0;
            state_nxt = ST_IDLE;
            clr_acc   = 1'b1;
          end else if (p_last) begin
            p_nxt = '0;
            h_nxt = h_r + 3'd1;
          end else begin
            p_nxt = p_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    acc_vld_nxt = acc_vld_r;
    if (s1_vld_r) begin
      acc_vld_nxt[s1_idx_r] = 1'b1;
    end
    if (clr_acc) begin
      acc_vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      h_r       <= '0;
      p_r       <= '0;
      s1_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      acc_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      h_r       <= h_nxt;
      p_r       <= p_nxt;
      s1_vld_r  <= issue_mac;
      d1_vld_r  <= issue_drain;
      acc_vld_r <= acc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    d1_res_r <= d1_res_nxt;
    s1_idx_r <= cur_idx;
    if (acc_re) begin
      rd_vld_r <= acc_vld_r[cur_idx];
    end
  end

  // weight store
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= cmd.value;
    end
    if (issue_mac) begin
      w_rd_r <= wmem[w_raddr];
    end
  end

  // accumulator store
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      accmem[s1_idx_r] <= acc_sum;
    end
    if (acc_re) begin
      acc_rd_r <= accmem[cur_idx];
    end
  end

endmodule

FILE: verif/tb.sv
// self-checking testbench for multihead_int8_linear_projection: loads weights,
// streams activation rows and checks every projection result against its own predictor
// depends on mhp_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;

  localparam int EMBED_MAX    = 64;
  localparam int PROJ_MAX     = 16;
  localparam int HEADS_MAX    = 4;
  localparam int SEQ_MAX      = 1024;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 80;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mhp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           push;
  logic                           full;
  logic                           in_operation;
  logic signed [7:0]              in_data_value;
  logic [1:0]                     in_weight_head;
  logic [3:0]                     in_weight_proj;
  logic [5:0]                     in_weight_elem;
  logic                           pop;
  logic                           empty;
  logic signed [7:0]              out_value;
  logic [1:0]                     out_head;
  logic [3:0]                     out_proj;
  logic [9:0]                     out_row;
  logic                           out_row_last;

  multihead_int8_linear_projection DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_data_value  (in_data_value),
    .in_weight_head (in_weight_head),
    .in_weight_proj (in_weight_proj),
    .in_weight_elem (in_weight_elem),
    .pop            (pop),
    .empty          (empty),
    .out_value      (out_value),
    .out_head       (out_head),
    .out_proj       (out_proj),
    .out_row        (out_row),
    .out_row_last   (out_row_last)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [7:0]          w_mem   [HEADS_MAX][PROJ_MAX][EMBED_MAX];
  bit                         w_known [HEADS_MAX][PROJ_MAX][EMBED_MAX];
  logic [mhp_pkg::ACC_W-1:0]  dot_acc [HEADS_MAX][PROJ_MAX];
  logic [mhp_pkg::ECNT_W-1:0] elem_cnt;
  logic [mhp_pkg::ROW_W-1:0]  row_cnt;
  logic [mhp_pkg::SEQ_W-1:0]  seq_reg;
  logic [mhp_pkg::LEN_W-1:0]  embed_reg;
  logic [mhp_pkg::PRJ_W-1:0]  proj_reg;
  logic [mhp_pkg::HDS_W-1:0]  head_reg;

  mhp_pkg::res_t pending_results[$];
  int   errors = 0;
  int   items_sent;
  int   results_seen = 0;
  int   rows_done;
  int   idle_cycles = 0;
  bit   quiet;

  function automatic void active_sizes(output int len, output int used,
                                       output int projs, output int heads);
    len = (embed_reg == 0) ? 1 : int'(embed_reg);
    if (len > EMBED_MAX) len = EMBED_MAX;
    used  = len & ~3;
    projs = ((proj_reg > PROJ_MAX) ? PROJ_MAX : int'(proj_reg)) & ~3;
    heads = (head_reg > HEADS_MAX) ? HEADS_MAX : int'(head_reg);
  endfunction

  function automatic void project_item(mhp_pkg::op_t op, logic signed [7:0] v,
                                       logic [1:0] h, logic [3:0] p, logic [5:0] e);
    int len, used, projs, heads, seq, nxt, s;
    logic signed [15:0] prod;
    mhp_pkg::res_t r;
    if (op == mhp_pkg::OP_WEIGHT) begin
      w_mem[h][p][e]   = v;
      w_known[h][p][e] = 1'b1;
      return;
    end
    active_sizes(len, used, projs, heads);
    if (elem_cnt < used) begin
      for (int hh = 0; hh < heads; hh++) begin
        for (int pp = 0; pp < projs; pp++) begin
          prod = v * w_mem[hh][pp][elem_cnt];
          dot_acc[hh][pp] = dot_acc[hh][pp] + {{(mhp_pkg::ACC_W-16){prod[15]}}, prod};
        end
      end
    end
    if (int'(elem_cnt) + 1 < len) begin
      elem_cnt = elem_cnt + 1'b1;
      return;
    end
    // row end: saturate and emit head by head
    for (int hh = 0; hh < heads; hh++) begin
      for (int pp = 0; pp < projs; pp++) begin
        s = $signed(dot_acc[hh][pp]);
        if (s > 127) s = 127;
        if (s < -128) s = -128;
        r.value = 8'(s);
        r.head  = 2'(hh);
        r.proj  = 4'(pp);
        r.row   = row_cnt;
        r.last  = (hh == heads - 1) && (pp == projs - 1);
        pending_results.push_back(r);
      end
    end
    for (int hh = 0; hh < HEADS_MAX; hh++) begin
      for (int pp = 0; pp < PROJ_MAX; pp++) begin
        dot_acc[hh][pp] = '0;
      end
    end
    elem_cnt = '0;
    seq = (seq_reg == 0) ? 1 : int'(seq_reg);
    if (seq > SEQ_MAX) seq = SEQ_MAX;
    nxt = int'(row_cnt) + 1;
    if (nxt >= seq) nxt = 0;
    row_cnt = mhp_pkg::ROW_W'(nxt);
    rows_done++;
  endfunction

  function automatic logic signed [7:0] rand_val();
    logic signed [7:0] v;
    case ($urandom_range(0, 5))
      0:       v = -8'sd128;
      1:       v = 8'sd127;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(mhp_pkg::op_t op, logic signed [7:0] v, logic [1:0] h,
                           logic [3:0] p, logic [5:0] e);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_operation   <= op;
    in_data_value  <= v;
    in_weight_head <= h;
    in_weight_proj <= p;
    in_weight_elem <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    project_item(op, v, h, p, e);
    items_sent++;
  endtask

  task automatic send_act(logic signed [7:0] v);
    send_item(mhp_pkg::OP_ACT, v, 2'($urandom), 4'($urandom), 6'($urandom));
  endtask

  task automatic send_weight(int h, int p, int e, logic signed [7:0] v);
    send_item(mhp_pkg::OP_WEIGHT, v, 2'(h), 4'(p), 6'(e));
  endtask

  // wait until the block has drained everything
  task automatic settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(mhp_pkg::reg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= mhp_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      mhp_pkg::REG_SEQ_LENGTH:   seq_reg   = mhp_pkg::SEQ_W'(val);
      mhp_pkg::REG_EMBED_LENGTH: embed_reg = mhp_pkg::LEN_W'(val);
      mhp_pkg::REG_PROJ_COUNT:   proj_reg  = mhp_pkg::PRJ_W'(val);
      mhp_pkg::REG_HEAD_COUNT:   head_reg  = mhp_pkg::HDS_W'(val);
      default: ;
    endcase
  endtask

  // program all four registers, then load any weight the new sizes will read
  task automatic configure(int seq, int emb, int prj, int hds);
    int len, used, projs, heads;
    settle();
    cfg_write(mhp_pkg::REG_SEQ_LENGTH, seq);
    cfg_write(mhp_pkg::REG_EMBED_LENGTH, emb);
    cfg_write(mhp_pkg::REG_PROJ_COUNT, prj);
    cfg_write(mhp_pkg::REG_HEAD_COUNT, hds);
    cfg_we <= 1'b0;
    active_sizes(len, used, projs, heads);
    for (int h = 0; h < heads; h++) begin
      for (int p = 0; p < projs; p++) begin
        for (int e = 0; e < used; e++) begin
          if (!w_known[h][p][e]) send_weight(h, p, e, rand_val());
        end
      end
    end
  endtask

  // reset sizes open a row, then shrinking the row below the count closes it
  task automatic test_reset_row();
    quiet = 1'b0;
    for (int h = 0; h < HEADS_MAX; h++) begin
      for (int p = 0; p < PROJ_MAX; p++) begin
        send_weight(h, p, 0, rand_val());
      end
    end
    send_act(rand_val());
    configure(1, 1, 16, 4);
    send_act(rand_val());
  endtask

  task automatic test_saturation();
    quiet = 1'b0;
    configure(3, 4, 4, 1);
    for (int e = 0; e < 4; e++) begin
      send_weight(0, 0, e, -8'sd128);
      send_weight(0, 1, e, 8'sd127);
      send_weight(0, 2, e, -8'sd1);
      send_weight(0, 3, e, e[0] ? 8'sd127 : -8'sd128);
    end
    repeat (4) send_act(-8'sd128);
    send_act(8'sd127);
    send_act(-8'sd128);
    send_act(8'sd0);
    send_act(8'sd1);
    repeat (4) send_act(8'sd0);
    send_act(8'sd1);
    repeat (3) send_act(8'sd0);
  endtask

  task automatic test_clamped_registers();
    quiet = 1'b0;
    configure(2047, 127, 4, 0);
    repeat (64) send_act(rand_val());
    configure(0, 3, 31, 7);
    repeat (5) send_act(rand_val());
    configure(1024, 3, 7, 2);
    repeat (6) send_act(rand_val());
    configure(6, 2, 16, 0);
    repeat (4) send_act(rand_val());
    configure(6, 2, 3, 2);
    repeat (2) send_act(rand_val());
    configure(6, 4, 4, 1);
    repeat (8) send_act(rand_val());
  endtask

  task automatic test_midrow_weights();
    quiet = 1'b1;
    configure(4, 4, 8, 1);
    send_act(rand_val());
    send_weight(0, 3, 2, -8'sd128);
    send_act(rand_val());
    send_act(rand_val());
    send_weight(0, 5, 0, 8'sd127);
    send_act(rand_val());
    repeat (4) send_act(rand_val());
  endtask

  task automatic test_random();
    int sent, phase_len, seq, emb, prj, hds;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       seq = 0;
        1:       seq = 1;
        2:       seq = SEQ_MAX;
        3:       seq = 2047;
        4:       seq = $urandom_range(0, 2047);
        default: seq = $urandom_range(2, 9);
      endcase
      if ($urandom_range(0, 4) == 0) begin
        emb = $urandom_range(10, 127);
        prj = $urandom_range(0, 7);
        hds = 0;
      end else begin
        emb = $urandom_range(0, 7);
        prj = $urandom_range(0, 9);
        hds = $urandom_range(0, 5);
      end
      configure(seq, emb, prj, hds);
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(15, 35);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_weight($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 63),
                      rand_val());
        end else begin
          send_act(rand_val());
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= mhp_pkg::REG_SEQ_LENGTH;
    cfg_data       <= '0;
    push           <= 1'b0;
    in_operation   <= mhp_pkg::OP_WEIGHT;
    in_data_value  <= '0;
    in_weight_head <= '0;
    in_weight_proj <= '0;
    in_weight_elem <= '0;
    items_sent   = 0;
    rows_done    = 0;
    quiet        = 1'b0;
    elem_cnt     = '0;
    row_cnt      = '0;
    seq_reg      = mhp_pkg::SEQ_W'(1);
    embed_reg    = mhp_pkg::LEN_W'(64);
    proj_reg     = mhp_pkg::PRJ_W'(16);
    head_reg     = mhp_pkg::HDS_W'(4);
    for (int h = 0; h < HEADS_MAX; h++) begin
      for (int p = 0; p < PROJ_MAX; p++) begin
        dot_acc[h][p] = '0;
        for (int e = 0; e < EMBED_MAX; e++) begin
          w_known[h][p][e] = 1'b0;
          w_mem[h][p][e]   = '0;
        end
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_row();
    test_saturation();
    test_clamped_registers();
    test_midrow_weights();
    test_random();
    settle();
    $display("run covered %0d input transactions and %0d rows", items_sent, rows_done);
    $display("%0d result transactions checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_checker
    int            gap;
    mhp_pkg::res_t exp_r;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: value %0d head %0d proj %0d row %0d",
               out_value, out_head, out_proj, out_row);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value) begin
          $error("out_value: expected %0d, got %0d", exp_r.value, out_value);
          errors++;
        end
        if (out_head !== exp_r.head) begin
          $error("out_head: expected %0d, got %0d", exp_r.head, out_head);
          errors++;
        end
        if (out_proj !== exp_r.proj) begin
          $error("out_proj: expected %0d, got %0d", exp_r.proj, out_proj);
          errors++;
        end
        if (out_row !== exp_r.row) begin
          $error("out_row: expected %0d, got %0d", exp_r.row, out_row);
          errors++;
        end
        if (out_row_last !== exp_r.last) begin
          $error("out_row_last: expected %0d, got %0d", exp_r.last, out_row_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
